/* hw/rtl/stq_pkg.sv */
// ----------------------------------------------------------------------------
// stq_pkg
// Operation codes, result kinds, sequencer types and the priority cap of the
// sorted timer event queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_MOVE     = 2'd2,
        OP_UPDATE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_SCHEDULED  = 3'd0,
        KIND_CANCELLED  = 3'd1,
        KIND_MOVED      = 3'd2,
        KIND_FIRED      = 3'd3,
        KIND_UPDATE     = 3'd4,
        KIND_FULL       = 3'd5,
        KIND_BAD_HANDLE = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        CONT_SCHED,
        CONT_CANCEL,
        CONT_MOVE,
        CONT_FIRE
    } cont_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_SH_CHK,
        ST_SH_WR,
        ST_INS_CHK,
        ST_INS_RD,
        ST_INS_CMP,
        ST_UPD_RD,
        ST_UPD_EV,
        ST_UPD_CMP,
        ST_FIRE_CHK,
        ST_FIRE_SEL,
        ST_FIRE_EV,
        ST_EMIT
    } state_t;

    localparam int unsigned PRIO_LOW = 2;

endpackage

/* hw/rtl/sorted_timer_event_queue_top.sv */
// ----------------------------------------------------------------------------
// sorted_timer_event_queue_top
// Timed event table kept in due-time order in an order memory and an event
// memory, walked by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// One input at a time. A schedule or move walks the list from the tail,
// reading the order memory and then the event memory for each entry; a
// cancel scans the order memory from the head for the slot and then shifts
// the later entries down; and an update reads each due entry from the head
// and then, for each fired event, scans from the head, does the removal
// shift and any re-insertion. Each result leaves through a one-entry output
// register, and the sequencer holds while it is still full.
module sorted_timer_event_queue_top #(
    parameter int MAX_EVENTS = 32,
    parameter int TIME_WIDTH = 40
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // op[1:0], handle[6:2], time_value, repeat_req, priority_req, zero fill
    input  logic [((10+TIME_WIDTH+7)/8)*8-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // slot[4:0], fired_priority[6:5], fire_time, rescheduled, zero fill
    output logic [((8+TIME_WIDTH+7)/8)*8-1:0]     m_tdata,
    // kind
    output logic [2:0]                            m_tuser,
    output logic                                  m_tlast
);

    localparam int AW    = $clog2(MAX_EVENTS);
    localparam int CW    = $clog2(MAX_EVENTS + 1);
    localparam int TW    = TIME_WIDTH;
    localparam int OUT_W = ((8 + TW + 7) / 8) * 8;
    localparam int T_LO  = 7;
    localparam int R_BIT = 7 + TW;
    localparam int P_LO  = 8 + TW;

    logic [1:0]    in_op;
    logic [4:0]    in_handle;
    logic [TW-1:0] in_time;
    logic          in_rep;
    logic [1:0]    in_prio;

    assign in_op     = s_tdata[1:0];
    assign in_handle = s_tdata[6:2];
    assign in_time   = s_tdata[T_LO+TW-1:T_LO];
    assign in_rep    = s_tdata[R_BIT];
    assign in_prio   = s_tdata[P_LO+1:P_LO];

    // memories
    logic [AW-1:0] order_mem [MAX_EVENTS];
    logic [TW-1:0] due_mem   [MAX_EVENTS];
    logic [TW-1:0] per_mem   [MAX_EVENTS];
    logic          rep_mem   [MAX_EVENTS];
    logic [1:0]    urg_mem   [MAX_EVENTS];

    logic          ord_re, ord_we;
    logic [AW-1:0] ord_raddr, ord_waddr, ord_wdata, ord_rdata;
    logic          ev_re, due_we, sched_we;
    logic [AW-1:0] ev_raddr, due_waddr;
    logic [TW-1:0] due_wdata, due_rdata, per_rdata;
    logic          rep_rdata;
    logic [1:0]    urg_rdata, urg_wdata;
    logic [TW-1:0] tval_reg_w;
    logic          rep_w;

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        if (ord_re)
        begin
            ord_rdata <= order_mem[ord_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (due_we)
        begin
            due_mem[due_waddr] <= due_wdata;
        end
        if (sched_we)
        begin
            per_mem[due_waddr] <= tval_reg_w;
            rep_mem[due_waddr] <= rep_w;
            urg_mem[due_waddr] <= urg_wdata;
        end
        if (ev_re)
        begin
            due_rdata <= due_mem[ev_raddr];
            per_rdata <= per_mem[ev_raddr];
            rep_rdata <= rep_mem[ev_raddr];
            urg_rdata <= urg_mem[ev_raddr];
        end
    end

    // state
    stq_pkg::state_t state_reg, state_next;
    stq_pkg::cont_t  cont_reg, cont_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [AW-1:0]   slot_reg, slot_next;
    logic [AW-1:0]   prev_reg, prev_next;
    logic [TW-1:0]   now_reg, now_next;
    logic [TW-1:0]   tval_reg, tval_next;
    logic [TW-1:0]   ins_due_reg, ins_due_next;
    logic [TW-1:0]   ft_reg, ft_next;
    logic [TW-1:0]   per_reg, per_next;
    logic            rep_reg, rep_next;
    logic [1:0]      urg_reg, urg_next;
    logic [MAX_EVENTS-1:0] valid_reg, valid_next;
    logic [MAX_EVENTS-1:0] pend_reg, pend_next;

    stq_pkg::kind_t  res_kind_reg, res_kind_next;
    logic [AW-1:0]   res_slot_reg, res_slot_next;
    logic [1:0]      res_prio_reg, res_prio_next;
    logic [TW-1:0]   res_time_reg, res_time_next;
    logic            res_resch_reg, res_resch_next;
    logic            res_last_reg, res_last_next;

    logic            out_valid_reg;
    logic [2:0]      out_kind_reg;
    logic            out_last_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic            out_load;

    logic            free_found;
    logic [AW-1:0]   free_idx;

    stq_free_slot #(
        .MAX_EVENTS(MAX_EVENTS)
    ) u_free (
        .valid(valid_reg),
        .found(free_found),
        .idx  (free_idx)
    );

    assign tval_reg_w = tval_next;
    assign rep_w      = in_rep;

    logic [31:0]   h32;
    logic [AW-1:0] h_idx;
    logic          h_ok;
    logic [TW:0]   sum_sched, sum_rep;
    logic [TW-1:0] due_sched, due_rep;

    assign h32       = 32'(in_handle);
    assign h_idx     = h32[AW-1:0];
    assign h_ok      = (h32 < 32'(MAX_EVENTS)) && valid_reg[h_idx];
    assign sum_sched = {1'b0, now_reg} + {1'b0, in_time};
    assign due_sched = sum_sched[TW] ? '1 : sum_sched[TW-1:0];
    assign sum_rep   = {1'b0, ft_reg} + {1'b0, per_reg};
    assign due_rep   = sum_rep[TW] ? '1 : sum_rep[TW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stq_pkg::ST_IDLE;
            count_reg <= '0;
            now_reg   <= '0;
            valid_reg <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            now_reg   <= now_next;
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cont_reg      <= cont_next;
        pos_reg       <= pos_next;
        slot_reg      <= slot_next;
        prev_reg      <= prev_next;
        tval_reg      <= tval_next;
        ins_due_reg   <= ins_due_next;
        ft_reg        <= ft_next;
        per_reg       <= per_next;
        rep_reg       <= rep_next;
        urg_reg       <= urg_next;
        res_kind_reg  <= res_kind_next;
        res_slot_reg  <= res_slot_next;
        res_prio_reg  <= res_prio_next;
        res_time_reg  <= res_time_next;
        res_resch_reg <= res_resch_next;
        res_last_reg  <= res_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cont_next      = cont_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        slot_next      = slot_reg;
        prev_next      = prev_reg;
        now_next       = now_reg;
        tval_next      = tval_reg;
        ins_due_next   = ins_due_reg;
        ft_next        = ft_reg;
        per_next       = per_reg;
        rep_next       = rep_reg;
        urg_next       = urg_reg;
        valid_next     = valid_reg;
        pend_next      = pend_reg;
        res_kind_next  = res_kind_reg;
        res_slot_next  = res_slot_reg;
        res_prio_next  = res_prio_reg;
        res_time_next  = res_time_reg;
        res_resch_next = res_resch_reg;
        res_last_next  = res_last_reg;
        ord_re         = 1'b0;
        ord_raddr      = pos_reg[AW-1:0];
        ord_we         = 1'b0;
        ord_waddr      = pos_reg[AW-1:0];
        ord_wdata      = slot_reg;
        ev_re          = 1'b0;
        ev_raddr       = ord_rdata;
        due_we         = 1'b0;
        sched_we       = 1'b0;
        due_waddr      = slot_reg;
        due_wdata      = tval_reg;
        urg_wdata      = (in_prio > 2'(stq_pkg::PRIO_LOW)) ? 2'(stq_pkg::PRIO_LOW) : in_prio;
        s_tready       = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                s_tready       = 1'b1;
                res_prio_next  = '0;
                res_time_next  = '0;
                res_resch_next = 1'b0;
                res_last_next  = 1'b1;
                res_slot_next  = h_idx;
                tval_next      = in_time;
                if (s_tvalid)
                begin
                    unique case (in_op) inside
                        stq_pkg::OP_SCHEDULE:
                        begin
                            if (!free_found || count_reg >= CW'(MAX_EVENTS))
                            begin
                                res_kind_next = stq_pkg::KIND_FULL;
                                res_slot_next = '0;
                                state_next    = stq_pkg::ST_EMIT;
                            end
                            else
                            begin
                                due_we              = 1'b1;
                                sched_we            = 1'b1;
                                due_waddr           = free_idx;
                                due_wdata           = due_sched;
                                valid_next[free_idx] = 1'b1;
                                slot_next           = free_idx;
                                ins_due_next        = due_sched;
                                pos_next            = count_reg;
                                cont_next           = stq_pkg::CONT_SCHED;
                                state_next          = stq_pkg::ST_INS_CHK;
                            end
                        end
                        stq_pkg::OP_CANCEL, stq_pkg::OP_MOVE:
                        begin
                            if (!h_ok)
                            begin
                                res_kind_next = stq_pkg::KIND_BAD_HANDLE;
                                state_next    = stq_pkg::ST_EMIT;
                            end
                            else
                            begin
                                slot_next  = h_idx;
                                pos_next   = '0;
                                cont_next  = (in_op == stq_pkg::OP_CANCEL) ?
                                             stq_pkg::CONT_CANCEL : stq_pkg::CONT_MOVE;
                                state_next = stq_pkg::ST_FIND_RD;
                            end
                        end
                        default:
                        begin
                            now_next   = in_time;
                            pos_next   = '0;
                            state_next = stq_pkg::ST_UPD_RD;
                        end
                    endcase
                end
            end
            stq_pkg::ST_FIND_RD:
            begin
                ord_re     = 1'b1;
                state_next = stq_pkg::ST_FIND_CHK;
            end
            stq_pkg::ST_FIND_CHK:
            begin
                if (ord_rdata == slot_reg)
                begin
                    state_next = stq_pkg::ST_SH_CHK;
                end
                else
                begin
                    pos_next   = pos_reg + CW'(1);
                    state_next = stq_pkg::ST_FIND_RD;
                end
            end
            stq_pkg::ST_SH_CHK:
            begin
                if (pos_reg + CW'(1) < count_reg)
                begin
                    ord_re     = 1'b1;
                    ord_raddr  = AW'(pos_reg + CW'(1));
                    state_next = stq_pkg::ST_SH_WR;
                end
                else
                begin
                    count_next    = count_reg - CW'(1);
                    res_slot_next = slot_reg;
                    unique case (cont_reg)
                        stq_pkg::CONT_CANCEL:
                        begin
                            valid_next[slot_reg] = 1'b0;
                            res_kind_next        = stq_pkg::KIND_CANCELLED;
                            state_next           = stq_pkg::ST_EMIT;
                        end
                        stq_pkg::CONT_MOVE:
                        begin
                            due_we       = 1'b1;
                            ins_due_next = tval_reg;
                            pos_next     = count_reg - CW'(1);
                            state_next   = stq_pkg::ST_INS_CHK;
                        end
                        default:
                        begin
                            res_kind_next  = stq_pkg::KIND_FIRED;
                            res_prio_next  = urg_reg;
                            res_time_next  = ft_reg;
                            res_resch_next = rep_reg;
                            res_last_next  = 1'b0;
                            if (rep_reg)
                            begin
                                due_we       = 1'b1;
                                due_wdata    = due_rep;
                                ins_due_next = due_rep;
                                pos_next     = count_reg - CW'(1);
                                state_next   = stq_pkg::ST_INS_CHK;
                            end
                            else
                            begin
                                valid_next[slot_reg] = 1'b0;
                                state_next           = stq_pkg::ST_EMIT;
                            end
                        end
                    endcase
                end
            end
            stq_pkg::ST_SH_WR:
            begin
                ord_we     = 1'b1;
                ord_wdata  = ord_rdata;
                pos_next   = pos_reg + CW'(1);
                state_next = stq_pkg::ST_SH_CHK;
            end
            stq_pkg::ST_INS_CHK:
            begin
                if (pos_reg == '0)
                begin
                    ord_we        = 1'b1;
                    count_next    = count_reg + CW'(1);
                    res_slot_next = slot_reg;
                    if (cont_reg == stq_pkg::CONT_SCHED)
                    begin
                        res_kind_next = stq_pkg::KIND_SCHEDULED;
                    end
                    else if (cont_reg == stq_pkg::CONT_MOVE)
                    begin
                        res_kind_next = stq_pkg::KIND_MOVED;
                    end
                    state_next = stq_pkg::ST_EMIT;
                end
                else
                begin
                    ord_re     = 1'b1;
                    ord_raddr  = AW'(pos_reg - CW'(1));
                    state_next = stq_pkg::ST_INS_RD;
                end
            end
            stq_pkg::ST_INS_RD:
            begin
                ev_re      = 1'b1;
                prev_next  = ord_rdata;
                state_next = stq_pkg::ST_INS_CMP;
            end
            stq_pkg::ST_INS_CMP:
            begin
                ord_we = 1'b1;
                if (due_rdata < ins_due_reg)
                begin
                    count_next    = count_reg + CW'(1);
                    res_slot_next = slot_reg;
                    if (cont_reg == stq_pkg::CONT_SCHED)
                    begin
                        res_kind_next = stq_pkg::KIND_SCHEDULED;
                    end
                    else if (cont_reg == stq_pkg::CONT_MOVE)
                    begin
                        res_kind_next = stq_pkg::KIND_MOVED;
                    end
                    state_next = stq_pkg::ST_EMIT;
                end
                else
                begin
                    ord_wdata  = prev_reg;
                    pos_next   = pos_reg - CW'(1);
                    state_next = stq_pkg::ST_INS_CHK;
                end
            end
            stq_pkg::ST_UPD_RD:
            begin
                if (pos_reg < count_reg)
                begin
                    ord_re     = 1'b1;
                    state_next = stq_pkg::ST_UPD_EV;
                end
                else
                begin
                    pos_next   = '0;
                    state_next = stq_pkg::ST_FIRE_CHK;
                end
            end
            stq_pkg::ST_UPD_EV:
            begin
                ev_re      = 1'b1;
                prev_next  = ord_rdata;
                state_next = stq_pkg::ST_UPD_CMP;
            end
            stq_pkg::ST_UPD_CMP:
            begin
                if (due_rdata < now_reg)
                begin
                    pend_next[prev_reg] = 1'b1;
                    pos_next            = pos_reg + CW'(1);
                    state_next          = stq_pkg::ST_UPD_RD;
                end
                else
                begin
                    pos_next   = '0;
                    state_next = stq_pkg::ST_FIRE_CHK;
                end
            end
            stq_pkg::ST_FIRE_CHK:
            begin
                if (pend_reg == '0)
                begin
                    res_kind_next  = stq_pkg::KIND_UPDATE;
                    res_slot_next  = '0;
                    res_prio_next  = '0;
                    res_time_next  = '0;
                    res_resch_next = 1'b0;
                    res_last_next  = 1'b1;
                    state_next     = stq_pkg::ST_EMIT;
                end
                else
                begin
                    ord_re     = 1'b1;
                    state_next = stq_pkg::ST_FIRE_SEL;
                end
            end
            stq_pkg::ST_FIRE_SEL:
            begin
                if (pend_reg[ord_rdata])
                begin
                    ev_re      = 1'b1;
                    slot_next  = ord_rdata;
                    state_next = stq_pkg::ST_FIRE_EV;
                end
                else
                begin
                    pos_next   = pos_reg + CW'(1);
                    state_next = stq_pkg::ST_FIRE_CHK;
                end
            end
            stq_pkg::ST_FIRE_EV:
            begin
                ft_next             = due_rdata;
                per_next            = per_rdata;
                rep_next            = rep_rdata;
                urg_next            = urg_rdata;
                pend_next[slot_reg] = 1'b0;
                cont_next           = stq_pkg::CONT_FIRE;
                state_next          = stq_pkg::ST_SH_CHK;
            end
            stq_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    pos_next = '0;
                    state_next = res_last_reg ? stq_pkg::ST_IDLE : stq_pkg::ST_FIRE_CHK;
                end
            end
            default:
            begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    logic [31:0]     res_slot32;
    logic [8+TW-1:0] out_bits;

    assign res_slot32 = 32'(res_slot_reg);
    assign out_bits   = {res_resch_reg, res_time_reg, res_prio_reg, res_slot32[4:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= OUT_W'(out_bits);
            out_kind_reg <= res_kind_reg;
            out_last_reg <= res_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hw/rtl/stq_free_slot.sv */
// ----------------------------------------------------------------------------
// stq_free_slot
// Lowest free slot finder over the slot valid bits.
// ----------------------------------------------------------------------------
module stq_free_slot #(
    parameter int MAX_EVENTS = 32
) (
    input  logic [MAX_EVENTS-1:0]         valid,
    output logic                          found,
    output logic [$clog2(MAX_EVENTS)-1:0] idx
);

    localparam int AW = $clog2(MAX_EVENTS);

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = MAX_EVENTS - 1; i >= 0; i--)
        begin
            if (!valid[i])
            begin
                found = 1'b1;
                idx   = AW'(i);
            end
        end
    end

endmodule

/* sim/tb_sorted_timer_event_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_timer_event_queue_top
// Self-checking bench for the sorted timer event queue. A scoreboard keeps
// its own ordered event table, predicts every result of each accepted
// request and compares the result stream field by field. Stimulus is a
// directed set of corner requests followed by random schedule, cancel, move
// and time update traffic with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_sorted_timer_event_queue_top;

    localparam int  NSLOT = 32;
    localparam int  TW    = 40;
    localparam int  SW    = ((10 + TW + 7) / 8) * 8;
    localparam int  MW    = ((8 + TW + 7) / 8) * 8;
    localparam longint CYCLE_LIMIT = 40000000;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    typedef struct {
        stq_pkg::op_t  op;
        logic [4:0]    handle;
        logic [TW-1:0] tval;
        logic          rep;
        logic [1:0]    prio;
    } request_t;

    typedef struct {
        stq_pkg::kind_t kind;
        logic [4:0]    slot;
        logic [1:0]    prio;
        logic [TW-1:0] ftime;
        logic          resch;
        logic          last;
    } outcome_t;

    class timer_scoreboard;
        bit            live[NSLOT];
        logic [TW-1:0] due[NSLOT];
        logic [TW-1:0] per[NSLOT];
        bit            reps[NSLOT];
        logic [1:0]    urg[NSLOT];
        int            order[NSLOT];
        int            cnt;
        logic [TW-1:0] now;
        outcome_t      pending[$];
        int            errors;

        function void clear();
            foreach (live[i])
                live[i] = 0;
            cnt = 0;
            now = '0;
            errors = 0;
        endfunction

        function logic [TW-1:0] sat_sum(logic [TW-1:0] a, logic [TW-1:0] b);
            logic [TW:0] s;
            s = a + b;
            return s[TW] ? TMAX : s[TW-1:0];
        endfunction

        function void unlink(int s);
            int p;
            p = 0;
            while (p < cnt && order[p] != s)
                p++;
            if (p == cnt)
                return;
            for (int q = p; q + 1 < cnt; q++)
                order[q] = order[q + 1];
            cnt--;
        endfunction

        function void link(int s);
            int p;
            p = cnt;
            if (cnt >= NSLOT)
                return;
            while (p > 0 && !(due[order[p - 1]] < due[s]))
                p--;
            for (int q = cnt; q > p; q--)
                order[q] = order[q - 1];
            order[p] = s;
            cnt++;
        endfunction

        function void push(stq_pkg::kind_t k, int s, logic [1:0] pr, logic [TW-1:0] t,
                           logic rs, logic lst);
            outcome_t o;
            o.kind = k;
            o.slot = s[4:0];
            o.prio = pr;
            o.ftime = t;
            o.resch = rs;
            o.last = lst;
            pending.push_back(o);
        endfunction

        function void note_request(request_t r);
            int s;
            int batch[NSLOT];
            int n;
            logic [TW-1:0] ft;
            s = 0;
            n = 0;
            case (r.op) inside
                stq_pkg::OP_SCHEDULE:
                begin
                    while (s < NSLOT && live[s])
                        s++;
                    if (s >= NSLOT || cnt >= NSLOT)
                    begin
                        push(stq_pkg::KIND_FULL, 0, 0, '0, 0, 1);
                        return;
                    end
                    live[s] = 1;
                    due[s] = sat_sum(now, r.tval);
                    per[s] = r.tval;
                    reps[s] = r.rep;
                    urg[s] = (r.prio > 2) ? 2'd2 : r.prio;
                    link(s);
                    push(stq_pkg::KIND_SCHEDULED, s, 0, '0, 0, 1);
                end
                stq_pkg::OP_CANCEL, stq_pkg::OP_MOVE:
                begin
                    s = int'(r.handle);
                    if (!live[s])
                    begin
                        push(stq_pkg::KIND_BAD_HANDLE, s, 0, '0, 0, 1);
                        return;
                    end
                    unlink(s);
                    if (r.op == stq_pkg::OP_CANCEL)
                    begin
                        live[s] = 0;
                        push(stq_pkg::KIND_CANCELLED, s, 0, '0, 0, 1);
                    end
                    else
                    begin
                        due[s] = r.tval;
                        link(s);
                        push(stq_pkg::KIND_MOVED, s, 0, '0, 0, 1);
                    end
                end
                default:
                begin
                    now = r.tval;
                    while (n < cnt && due[order[n]] < now)
                    begin
                        batch[n] = order[n];
                        n++;
                    end
                    for (int i = 0; i < n; i++)
                    begin
                        s = batch[i];
                        ft = due[s];
                        unlink(s);
                        if (reps[s])
                        begin
                            due[s] = sat_sum(ft, per[s]);
                            link(s);
                        end
                        else
                            live[s] = 0;
                        push(stq_pkg::KIND_FIRED, s, urg[s], ft, reps[s], 0);
                    end
                    push(stq_pkg::KIND_UPDATE, 0, 0, '0, 0, 1);
                end
            endcase
        endfunction

        function void check_result(outcome_t a);
            outcome_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d slot=%0d", $time, a.kind, a.slot);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind)
                report("kind", e.kind, a.kind);
            if (a.slot !== e.slot)
                report("slot", e.slot, a.slot);
            if (a.prio !== e.prio)
                report("fired_priority", e.prio, a.prio);
            if (a.ftime !== e.ftime)
                report("fire_time", e.ftime, a.ftime);
            if (a.resch !== e.resch)
                report("rescheduled", e.resch, a.resch);
            if (a.last !== e.last)
                report("last", e.last, a.last);
        endfunction

        function void report(string f, logic [TW-1:0] e, logic [TW-1:0] a);
            $display("%0t: %s mismatch expected %0h actual %0h", $time, f, e, a);
            errors++;
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [SW-1:0] s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [MW-1:0] m_tdata;
    logic [2:0]    m_tuser;
    logic          m_tlast;

    timer_scoreboard sb;
    bit     quiet;
    bit     hold_req;
    int     hold_cnt;
    int     stall_cnt;
    longint cycles;

    sorted_timer_event_queue_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_req = 0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    stall_cnt = $urandom_range(1, 11);
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t a;
        if (rst_n && m_tvalid && m_tready)
        begin
            a.kind = stq_pkg::kind_t'(m_tuser);
            a.slot = m_tdata[4:0];
            a.prio = m_tdata[6:5];
            a.ftime = m_tdata[7 +: TW];
            a.resch = m_tdata[7 + TW];
            a.last = m_tlast;
            sb.check_result(a);
        end
    end

    function automatic logic [TW-1:0] any_time();
        return {8'($urandom_range(0, 255)), 32'($urandom())};
    endfunction

    task automatic send(request_t r);
        s_tvalid <= 1'b1;
        s_tdata <= {{(SW - 10 - TW){1'b0}}, r.prio, r.rep, r.tval, r.handle, r.op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(r);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_op(stq_pkg::op_t op, int h, logic [TW-1:0] t, logic rep,
                           logic [1:0] pr);
        request_t r;
        r.op = op;
        r.handle = h[4:0];
        r.tval = t;
        r.rep = rep;
        r.prio = pr;
        send(r);
    endtask

    task automatic send_random(int sched_weight);
        request_t r;
        int w;
        w = $urandom_range(0, 99);
        r.handle = 5'($urandom_range(0, NSLOT - 1));
        r.rep = 1'($urandom_range(0, 1));
        r.prio = 2'($urandom_range(0, 3));
        if (w < sched_weight)
        begin
            r.op = stq_pkg::OP_SCHEDULE;
            r.tval = ($urandom_range(0, 15) == 0) ? any_time() : TW'($urandom_range(0, 400));
        end
        else if (w < sched_weight + (100 - sched_weight) / 4)
            r.op = stq_pkg::OP_CANCEL;
        else if (w < sched_weight + (100 - sched_weight) / 2)
            r.op = stq_pkg::OP_MOVE;
        else
            r.op = stq_pkg::OP_UPDATE;
        if (r.op != stq_pkg::OP_SCHEDULE)
        begin
            case ($urandom_range(0, 9))
                0: r.tval = any_time();
                1: r.tval = TW'($urandom_range(0, 300));
                default: r.tval = sb.sat_sum(sb.now, TW'($urandom_range(0, 300)));
            endcase
        end
        send(r);
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        cycles = 0;
        quiet = 0;
        hold_req = 0;
        hold_cnt = 0;
        stall_cnt = 0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(stq_pkg::OP_UPDATE, 0, '0, 0, 0);
        send_op(stq_pkg::OP_SCHEDULE, 0, '0, 0, 0);
        send_op(stq_pkg::OP_SCHEDULE, 0, TMAX, 1, 3);
        send_op(stq_pkg::OP_SCHEDULE, 0, 40'd10, 1, 1);
        send_op(stq_pkg::OP_SCHEDULE, 0, 40'd10, 0, 2);
        send_op(stq_pkg::OP_SCHEDULE, 0, 40'd7, 0, 1);
        send_op(stq_pkg::OP_CANCEL, 20, '0, 0, 0);
        send_op(stq_pkg::OP_MOVE, 31, 40'd3, 0, 0);
        send_op(stq_pkg::OP_CANCEL, 4, '0, 0, 0);
        send_op(stq_pkg::OP_MOVE, 0, 40'd5, 0, 0);
        send_op(stq_pkg::OP_UPDATE, 0, 40'd0, 0, 0);
        send_op(stq_pkg::OP_UPDATE, 0, 40'd30, 0, 0);
        send_op(stq_pkg::OP_SCHEDULE, 0, 40'd1, 1, 0);
        send_op(stq_pkg::OP_UPDATE, 0, TMAX, 0, 0);
        send_op(stq_pkg::OP_SCHEDULE, 0, 40'd5, 0, 1);
        send_op(stq_pkg::OP_CANCEL, 1, '0, 0, 0);
        send_op(stq_pkg::OP_CANCEL, 2, '0, 0, 0);
        send_op(stq_pkg::OP_UPDATE, 0, 40'd0, 0, 0);
        send_op(stq_pkg::OP_MOVE, 0, '0, 0, 0);
        send_op(stq_pkg::OP_CANCEL, 0, '0, 0, 0);

        for (int i = 0; i < 500; i++)
        begin
            if (i == 100)
                hold_req = 1;
            if (i == 300)
                drain();
            if (i >= 420)
                quiet = 1;
            send_random((i >= 150 && i < 250) ? 85 : 40);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300)
            @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/stq_pkg.sv
hw/rtl/stq_free_slot.sv
hw/rtl/sorted_timer_event_queue_top.sv
sim/tb_sorted_timer_event_queue_top.sv
